/* rtl/mlpq_pkg.sv */
// Shared package of the multilevel priority FIFO.
// Holds default sizes, field widths, codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlpq_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = 40;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DATA
  } state_e;

endpackage

`default_nettype wire

/* rtl/multilevel_priority_fifo.sv */
// Top level of the multilevel priority FIFO: controller, level select and result register.
// Depends on mlpq_pkg, mlpq_entry_ram and mlpq_meta_ram.
//
// Usage. Words arrive on the slave stream (s_axis_*). tuser carries the mode: enqueue
// or dequeue. An enqueue appends the value to the ring of the requested level. A
// dequeue takes the oldest word of the lowest-numbered level that holds one. Every
// input word yields exactly one result word on the master stream (m_axis_*) with
// the data, the level and a status: ok, queue empty on dequeue, or level full
// (or nonexistent) on enqueue, in which case the word is dropped.
// Timing. After a word is accepted the level's ring state is read from the meta RAM,
// which has a registered read. An enqueue or an empty dequeue is decided in S_CHECK,
// so its result is loaded and the controller returns to idle for the next word. A
// served dequeue also reads the entry RAM in S_CHECK and loads its result in S_DATA.
// The registered reads of the two RAMs set these steps.
// Stalls. The result sits in an output register; a new word is accepted while it waits.
// If the receiver still holds off when the next result is ready, the controller waits
// in place until the result register is free. Only a served dequeue updates its ring before.
// Reset. rst_ni clears every level to empty. The entry RAM needs no clearing because
// only written entries are ever read back.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_fifo
  import mlpq_pkg::*;
#(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata: value [31:0], priority_req [34:32], zero [39:35]
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,
  // tuser: mode [0]
  input  wire logic [0:0]         s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // tdata: data_out [31:0], level_out [34:32], zero [39:35]
  output logic      [TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status [1:0]
  output logic      [STATUS_W-1:0] m_axis_tuser_o
);

  localparam int LW    = $clog2(LEVELS);
  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int MW    = 2 * PW + CW;
  localparam int TOTAL = LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(TOTAL);

  // Input fields.
  logic              in_acc;
  mode_e             in_mode;
  logic [VALUE_W-1:0] in_value;
  logic [PRIO_W-1:0] in_req;
  logic              in_bad;

  assign in_mode  = mode_e'(s_axis_tuser_i[0]);
  assign in_value = s_axis_tdata_i[VALUE_W-1:0];
  assign in_req   = s_axis_tdata_i[VALUE_W+PRIO_W-1:VALUE_W];
  assign in_bad   = (32'(in_req) >= LEVELS);

  // One flag per level that holds at least one word; the lowest set flag is served.
  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic [LW-1:0]     top_lv;

  always_comb begin
    top_lv = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        top_lv = LW'(i);
      end
    end
  end

  // Registered item.
  state_e             state_q, state_d;
  mode_e              mode_q;
  logic [VALUE_W-1:0] value_q;
  logic [PRIO_W-1:0]  req_q;
  logic [LW-1:0]      lvl_q;
  logic               bad_q;
  logic               any_q;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  out_data_q, out_data_d;
  logic [PRIO_W-1:0]   out_level_q, out_level_d;
  status_e             out_status_q, out_status_d;
  logic                out_free;
  logic                out_load;

  // RAM ports.
  logic          meta_rd_en, meta_wr_en;
  logic [LW-1:0] meta_rd_addr;
  logic [MW-1:0] meta_rd_data, meta_wr_data;
  logic [PW-1:0] m_head, m_tail, head_nx, tail_nx;
  logic [CW-1:0] m_count;
  logic          ent_wr_en, ent_rd_en;
  logic [AW-1:0] ent_wr_addr, ent_rd_addr;
  logic [DATA_WIDTH-1:0]        ent_wr_data;
  logic signed [DATA_WIDTH-1:0] ent_rd_data;
  logic signed [63:0]           value_ext;

  assign {m_head, m_tail, m_count} = meta_rd_data;
  assign head_nx = (m_head == PW'(LEVEL_DEPTH - 1)) ? '0 : m_head + 1'b1;
  assign tail_nx = (m_tail == PW'(LEVEL_DEPTH - 1)) ? '0 : m_tail + 1'b1;

  assign value_ext   = 64'($signed(value_q));
  assign ent_wr_data = DATA_WIDTH'(value_ext);
  assign ent_wr_addr = AW'(lvl_q) * AW'(LEVEL_DEPTH) + AW'(m_tail);
  assign ent_rd_addr = AW'(lvl_q) * AW'(LEVEL_DEPTH) + AW'(m_head);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // The meta read is issued in the acceptance cycle at the level the item will touch.
  assign meta_rd_addr = (in_mode == MODE_DEQ) ? top_lv : LW'(in_req);
  assign meta_rd_en   = in_acc && ((in_mode == MODE_DEQ) ? (nonempty_q != '0) : !in_bad);

  always_comb begin
    state_d      = state_q;
    nonempty_d   = nonempty_q;
    meta_wr_en   = 1'b0;
    meta_wr_data = meta_rd_data;
    ent_wr_en    = 1'b0;
    ent_rd_en    = 1'b0;
    out_load     = 1'b0;
    out_data_d   = '0;
    out_level_d  = req_q;
    out_status_d = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mode_q == MODE_ENQ) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
            if (bad_q || (m_count >= CW'(LEVEL_DEPTH))) begin
              out_status_d = ST_FULL;
            end else begin
              ent_wr_en         = 1'b1;
              meta_wr_en        = 1'b1;
              meta_wr_data      = {m_head, tail_nx, m_count + 1'b1};
              nonempty_d[lvl_q] = 1'b1;
            end
          end
        end else if (!any_q) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_level_d  = '0;
            out_status_d = ST_EMPTY;
            state_d      = S_IDLE;
          end
        end else begin
          // Fetch the head word and retire it from the ring right away.
          ent_rd_en    = 1'b1;
          meta_wr_en   = 1'b1;
          meta_wr_data = {head_nx, m_tail, m_count - 1'b1};
          if (m_count == CW'(1)) begin
            nonempty_d[lvl_q] = 1'b0;
          end
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_data_d  = VALUE_W'(ent_rd_data);
          out_level_d = PRIO_W'(lvl_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= in_mode;
      value_q <= in_value;
      req_q   <= in_req;
      lvl_q   <= meta_rd_addr;
      bad_q   <= in_bad;
      any_q   <= (nonempty_q != '0);
    end
    if (out_load) begin
      out_data_q   <= out_data_d;
      out_level_q  <= out_level_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(TDATA_W - VALUE_W - PRIO_W)'(0), out_level_q, out_data_q};
  assign m_axis_tuser_o  = out_status_q;

  mlpq_meta_ram #(
    .LEVELS (LEVELS),
    .LW     (LW),
    .MW     (MW)
  ) u_meta (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (meta_rd_en),
    .rd_addr_i (meta_rd_addr),
    .rd_data_o (meta_rd_data),
    .wr_en_i   (meta_wr_en),
    .wr_addr_i (lvl_q),
    .wr_data_i (meta_wr_data)
  );

  mlpq_entry_ram #(
    .DEPTH (TOTAL),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_entry (
    .clk_i     (clk_i),
    .wr_en_i   (ent_wr_en),
    .wr_addr_i (ent_wr_addr),
    .wr_data_i (ent_wr_data),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (ent_rd_addr),
    .rd_data_o (ent_rd_data)
  );

  // An empty status is only reported when no level holds a word.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_status_d == ST_EMPTY)) |-> (nonempty_q == '0))
    else $error("empty status while a level holds words");

  // A served dequeue always picks a level flagged as holding a word.
  a_deq_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) && (mode_q == MODE_DEQ) && any_q) |->
      (nonempty_q[lvl_q] && (m_count != '0)))
    else $error("dequeue from an empty level");

  // A level never holds more words than its ring depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) && !bad_q) |-> (m_count <= CW'(LEVEL_DEPTH)))
    else $error("level count beyond ring depth");

  // After a served dequeue the result is loaded from the entry RAM path.
  a_deq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) && (mode_q == MODE_DEQ) && any_q) |=> (state_q == S_DATA))
    else $error("served dequeue did not wait for entry data");

endmodule

`default_nettype wire

/* rtl/mlpq_entry_ram.sv */
// Word storage of the multilevel priority FIFO: one simple dual-port RAM.
// Synchronous write, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mlpq_entry_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/mlpq_meta_ram.sv */
// Per-level ring state (head, tail, count) of the multilevel priority FIFO.
// Registered-read RAM with one valid bit per level; an unwritten level reads as zero.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mlpq_meta_ram #(
  parameter int LEVELS = 8,
  parameter int LW     = 3,
  parameter int MW     = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [LW-1:0] rd_addr_i,
  output logic      [MW-1:0] rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [LW-1:0] wr_addr_i,
  input  wire logic [MW-1:0] wr_data_i
);

  logic [MW-1:0]     mem [LEVELS];
  logic [LEVELS-1:0] valid_q;
  logic [MW-1:0]     rd_data_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench of the multilevel priority FIFO.
// Depends on mlpq_pkg and multilevel_priority_fifo; a scoreboard class predicts every result.
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0]        data;
  logic [2:0]         level;
  mlpq_pkg::status_e  status;
} queue_result_t;

// Keeps its own copy of every level's ring and the results still owed by the block.
class prio_queue_model;
  localparam int NLEV  = mlpq_pkg::LEVELS_DEF;
  localparam int DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF;
  localparam int DW    = mlpq_pkg::DATA_WIDTH_DEF;

  logic [DW-1:0]  ring [NLEV][DEPTH];
  int             head [NLEV];
  int             tail [NLEV];
  int             fill [NLEV];
  queue_result_t  pending_results [$];
  int             mismatch_count;

  function new();
    foreach (head[i]) begin
      head[i] = 0;
      tail[i] = 0;
      fill[i] = 0;
    end
    mismatch_count = 0;
  endfunction

  // Applies one accepted word to the rings and queues the result it must produce.
  function void accept_word(mlpq_pkg::mode_e mode, logic [31:0] value, logic [2:0] prio);
    queue_result_t r;
    int            lv;
    longint        wide;
    r.data   = '0;
    r.level  = '0;
    r.status = mlpq_pkg::ST_OK;
    if (mode == mlpq_pkg::MODE_ENQ) begin
      r.level = prio;
      // A level that does not exist is treated like a full one.
      if (int'(prio) >= NLEV || fill[prio] >= DEPTH) begin
        r.status = mlpq_pkg::ST_FULL;
      end else begin
        wide = longint'($signed(value));
        ring[prio][tail[prio]] = wide[DW-1:0];
        tail[prio] = (tail[prio] + 1) % DEPTH;
        fill[prio]++;
      end
    end else begin
      lv = 0;
      while (lv < NLEV && fill[lv] == 0) lv++;
      if (lv == NLEV) begin
        r.status = mlpq_pkg::ST_EMPTY;
      end else begin
        wide = longint'($signed(ring[lv][head[lv]]));
        r.data  = wide[31:0];
        r.level = lv[2:0];
        head[lv] = (head[lv] + 1) % DEPTH;
        fill[lv]--;
      end
    end
    pending_results.push_back(r);
  endfunction

  // Compares one result word against the oldest outstanding prediction.
  function void check_result(logic [mlpq_pkg::TDATA_W-1:0] tdata,
                             logic [mlpq_pkg::STATUS_W-1:0] tuser);
    queue_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual data=%h level=%0d status=%0d",
               $time, tdata[31:0], tdata[34:32], tuser);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (tdata[31:0] !== want.data) begin
      $display("%0t: data mismatch, expected %h, actual %h", $time, want.data, tdata[31:0]);
      mismatch_count++;
    end
    if (tdata[34:32] !== want.level) begin
      $display("%0t: level mismatch, expected %0d, actual %0d",
               $time, want.level, tdata[34:32]);
      mismatch_count++;
    end
    if (tuser !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, tuser);
      mismatch_count++;
    end
  endfunction
endclass

module tb;
  import mlpq_pkg::*;

  localparam int RANDOM_WORDS = 1200;
  localparam int QUIET_FROM   = 1050;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_valid;
  logic [TDATA_W-1:0]   s_data;
  logic [0:0]           s_user;
  logic                 m_ready;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [TDATA_W-1:0]   m_axis_tdata_o;
  logic [STATUS_W-1:0]  m_axis_tuser_o;

  // Idling controls, changed per phase by the stimulus.
  bit                   quiet_tail;
  int                   send_gap_pct;
  int                   recv_stall_pct;

  prio_queue_model      queue_model;

  multilevel_priority_fifo dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Offers one word, with an optional idle burst before it, and waits for the handshake.
  task automatic push_word(input mode_e mode, input logic [31:0] value,
                           input logic [2:0] prio);
    if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {5'b0, prio, value};
    s_user  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    queue_model.accept_word(mode, value, prio);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts on tready.
  initial begin
    m_ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 99) < recv_stall_pct) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      queue_model.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int          sent;
    int          phase_kind;
    int          phase_len;
    int          deq_pct;
    logic [2:0]  hot_level;
    logic [2:0]  prio;
    mode_e       mode;
    queue_model    = new();
    quiet_tail     = 1'b0;
    send_gap_pct   = 25;
    recv_stall_pct = 20;
    rst_ni  <= 1'b0;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= MODE_ENQ;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty dequeue, extreme values on the outer levels, one level
    // filled until an enqueue is refused, then dequeues that show the level order.
    push_word(MODE_DEQ, 32'h1234_5678, 3'd7);
    push_word(MODE_ENQ, 32'h8000_0000, 3'd7);
    push_word(MODE_ENQ, 32'h7fff_ffff, 3'd0);
    push_word(MODE_ENQ, 32'h0000_0000, 3'd3);
    push_word(MODE_ENQ, 32'hffff_ffff, 3'd7);
    repeat (LEVEL_DEPTH_DEF - 1) push_word(MODE_ENQ, $urandom, 3'd3);
    push_word(MODE_ENQ, 32'hdead_beef, 3'd3);
    repeat (4) push_word(MODE_DEQ, $urandom, 3'($urandom_range(0, 7)));

    // Random part in phases: filling phases mostly enqueue, draining phases mostly
    // dequeue, mixed phases keep pointers wrapping.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = $urandom_range(10, 60);
      hot_level  = 3'($urandom_range(0, 7));
      case (phase_kind)
        0:       deq_pct = 10;
        1:       deq_pct = 85;
        default: deq_pct = 45;
      endcase
      case ($urandom_range(0, 2))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 25;
        default: send_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       recv_stall_pct = 0;
        1:       recv_stall_pct = 15;
        default: recv_stall_pct = 40;
      endcase
      repeat (phase_len) begin
        if (sent >= QUIET_FROM) quiet_tail = 1'b1;
        mode = ($urandom_range(0, 99) < deq_pct) ? MODE_DEQ : MODE_ENQ;
        prio = ($urandom_range(0, 99) < 60) ? hot_level : 3'($urandom_range(0, 7));
        push_word(mode, pick_value(), prio);
        sent++;
      end
    end
    s_valid <= 1'b0;

    while (queue_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (queue_model.mismatch_count == 0 && queue_model.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
